>>> hdl/aebs_pkg.sv
// ----------------------------------------------------------------------------
// aebs_pkg
// Shared types and constants of the audio elastic buffer with frame slip.
// ----------------------------------------------------------------------------
`default_nettype none

package aebs_pkg;

	localparam int RING_FRAMES_DEF     = 48000;
	localparam int MAX_READ_FRAMES_DEF = 64;
	localparam int START_DELAY_MS      = 30;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 7;
	localparam int LAG_W    = 9;
	localparam int TOTAL_W  = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DUP_LAG    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_EXTRA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWAP       = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [1:0] ADJ_NONE   = 2'd0;
	localparam logic [1:0] ADJ_SKIP   = 2'd1;
	localparam logic [1:0] ADJ_REPEAT = 2'd2;

	typedef struct packed {
		logic                action;
		logic [SAMPLE_W-1:0] sample;
		logic [COUNT_W-1:0]  frame_count;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_word;
		logic [SAMPLE_W-1:0] right_word;
		logic                last_frame;
		logic [1:0]          adjustment;
		logic [TOTAL_W-1:0]  skips_so_far;
		logic [TOTAL_W-1:0]  repeats_so_far;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LAG,
		ST_MARK,
		ST_CMP,
		ST_ADJ,
		ST_STREAM
	} state_t;

endpackage

`default_nettype wire

>>> hdl/aebs_ram.sv
// ----------------------------------------------------------------------------
// aebs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aebs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/audio_elastic_buffer_slip.sv
// ----------------------------------------------------------------------------
// audio_elastic_buffer_slip
// Audio ring buffer that skips or repeats one frame per read block to
// follow clock drift between writer and reader.
//
// Items enter on start/request and are taken when start is high and busy low.
// A write item stores one mono sample and completes in the accept cycle; a
// new item may follow in the next cycle. A read item asks for frame_count
// frames (saturated to MAX_READ_FRAMES, zero is dropped). It passes through
// the LAG, MARK, CMP and ADJ states computing lag marks and the slip
// decision, then issues one frame address per cycle to two sample banks
// (even and odd words); each frame appears on result in the cycle after its
// address, marked by strobe for one cycle. Busy stays high through those
// states and the issue of its frames, and its last frame leaves in the same
// cycle as busy falls. The receiver cannot stall. After reset both banks
// are swept to zero, one frame per cycle, over all RING_FRAMES addresses;
// busy stays high meanwhile, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_elastic_buffer_slip
	import aebs_pkg::*;
#(
	parameter int RING_FRAMES     = RING_FRAMES_DEF,
	parameter int MAX_READ_FRAMES = MAX_READ_FRAMES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_item_t             request,
	output logic                      strobe,
	output out_item_t                 result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LAG_W-1:0]     cfg_data
);

	localparam int FW  = $clog2(RING_FRAMES);
	localparam int WPW = FW + 1;
	localparam int FPM = RING_FRAMES / 1000;

	localparam logic [FW:0]    FPM_F     = (FW+1)'(FPM);
	localparam logic [FW-1:0]  LAST_F    = FW'(RING_FRAMES - 1);
	localparam logic [FW-1:0]  RING_F    = FW'(RING_FRAMES);
	localparam logic [FW-1:0]  MARK_LOW  = FW'(RING_FRAMES / 4 * 1);
	localparam logic [FW-1:0]  MARK_HIGH = FW'(RING_FRAMES / 4 * 3);
	localparam logic [FW-1:0]  RP_RST    = FW'(RING_FRAMES - FPM * START_DELAY_MS);
	localparam logic [WPW-1:0] WP_LAST   = WPW'(2 * RING_FRAMES - 1);
	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_READ_FRAMES);

	function automatic logic [FW-1:0] ring_back(input logic [FW-1:0] pos,
		input logic [FW-1:0] amt);
		logic [FW:0] diff;
		diff = {1'b0, pos} - {1'b0, amt};
		return diff[FW] ? FW'(diff[FW-1:0] + RING_F) : diff[FW-1:0];
	endfunction

	function automatic logic [FW-1:0] ring_fold(input logic [FW:0] v);
		return (v >= (FW+1)'(RING_FRAMES)) ? FW'(v - (FW+1)'(RING_FRAMES)) : v[FW-1:0];
	endfunction

	function automatic logic wrap_before(input logic [FW-1:0] a,
		input logic [FW-1:0] b);
		logic r;
		if (b < MARK_LOW && MARK_HIGH < a) begin
			r = 1'b1;
		end else if (a < MARK_LOW && MARK_HIGH < b) begin
			r = 1'b0;
		end else begin
			r = a < b;
		end
		return r;
	endfunction

	function automatic logic wrap_after(input logic [FW-1:0] a,
		input logic [FW-1:0] b);
		logic r;
		if (a < MARK_LOW && MARK_HIGH < b) begin
			r = 1'b1;
		end else if (b < MARK_LOW && MARK_HIGH < a) begin
			r = 1'b0;
		end else begin
			r = a > b;
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [LAG_W-1:0]   dup_lag_q, skip_extra_q;
	logic [WPW-1:0]     wp_q;
	logic [FW-1:0]      rp_q;
	logic [FW-1:0]      clr_q;
	logic [COUNT_W-1:0] cnt_q, idx_q;
	logic [FW-1:0]      amt_s_q, amt_d_q, ws_q, wd_q, next_q, da_q, db_q, addr_q;
	logic               ws_lt_q, wd_lt_q, bef_q, aft_q;
	logic [1:0]         adj_q, adj_d;
	logic [TOTAL_W-1:0] skip_q, rep_q;
	logic               strobe_s1, last_s1;

	logic               accept, wr_acc, rd_acc, clearing, streaming, last_issue;
	logic [FW-1:0]      next_sum, m_adj, addr_inc;
	logic [LAG_W:0]     lag_sum;
	logic [FW:0]        amt_s_full, amt_d_full;
	logic [COUNT_W-1:0] cnt_sat;
	logic               even_we, odd_we;
	logic [FW-1:0]      waddr;
	logic [SAMPLE_W-1:0] wdata, even_q, odd_q;

	assign accept   = start && !busy;
	assign wr_acc   = accept && request.action == ACT_WRITE;
	assign rd_acc   = accept && request.action == ACT_READ && request.frame_count != '0;
	assign cnt_sat  = (request.frame_count > MAX_CNT) ? MAX_CNT : request.frame_count;
	assign lag_sum  = {1'b0, dup_lag_q} + {1'b0, skip_extra_q};
	assign amt_s_full = FPM_F * (FW+1)'(lag_sum);
	assign amt_d_full = FPM_F * (FW+1)'(dup_lag_q);
	assign last_issue = streaming && idx_q == cnt_q - COUNT_W'(1);
	assign addr_inc = (addr_q == LAST_F) ? '0 : addr_q + FW'(1);

	always_comb begin
		logic [FW:0] s;
		s = {1'b0, rp_q} + (FW+1)'(cnt_q);
		next_sum = (s >= (FW+1)'(RING_FRAMES)) ? FW'(s - (FW+1)'(RING_FRAMES)) : s[FW-1:0];
	end

	always_comb begin
		adj_d = ADJ_NONE;
		if (ws_lt_q) begin
			if (bef_q) begin
				adj_d = ADJ_SKIP;
			end else if (aft_q) begin
				adj_d = ADJ_REPEAT;
			end
		end else if (wd_lt_q) begin
			if (aft_q && bef_q) begin
				adj_d = (da_q > db_q) ? ADJ_REPEAT : ADJ_SKIP;
			end
		end
		case (adj_d)
			ADJ_SKIP:   m_adj = (rp_q == LAST_F) ? '0 : rp_q + FW'(1);
			ADJ_REPEAT: m_adj = (rp_q == '0) ? LAST_F : rp_q - FW'(1);
			default:    m_adj = rp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		clearing  = 1'b0;
		streaming = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == LAST_F) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (rd_acc) begin
					state_d = ST_LAG;
				end
			end
			ST_LAG:  state_d = ST_MARK;
			ST_MARK: state_d = ST_CMP;
			ST_CMP:  state_d = ST_ADJ;
			ST_ADJ:  state_d = ST_STREAM;
			ST_STREAM: begin
				streaming = 1'b1;
				if (last_issue) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_lag_q    <= '0;
			skip_extra_q <= '0;
			wp_q         <= WPW'(1);
			rp_q         <= RP_RST;
			clr_q        <= '0;
			skip_q       <= '0;
			rep_q        <= '0;
			adj_q        <= ADJ_NONE;
			strobe_s1    <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			strobe_s1 <= streaming;
			last_s1   <= last_issue;
			if (clearing) begin
				clr_q <= clr_q + FW'(1);
			end
			if (wr_acc) begin
				wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + WPW'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DUP_LAG:    dup_lag_q <= cfg_data;
					CFG_SKIP_EXTRA: skip_extra_q <= cfg_data;
					CFG_SWAP:       wp_q <= cfg_data[0] ? WPW'(0) : WPW'(1);
					default:        ;
				endcase
			end
			if (state_q == ST_ADJ) begin
				adj_q <= adj_d;
				rp_q  <= m_adj;
				if (adj_d == ADJ_SKIP && skip_q != '1) begin
					skip_q <= skip_q + TOTAL_W'(1);
				end
				if (adj_d == ADJ_REPEAT && rep_q != '1) begin
					rep_q <= rep_q + TOTAL_W'(1);
				end
			end
			if (last_issue) begin
				rp_q <= addr_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			cnt_q <= cnt_sat;
		end
		case (state_q)
			ST_LAG: begin
				amt_s_q <= ring_fold(amt_s_full);
				amt_d_q <= ring_fold(amt_d_full);
				next_q  <= next_sum;
			end
			ST_MARK: begin
				ws_q <= ring_back(wp_q[WPW-1:1], amt_s_q);
				wd_q <= ring_back(wp_q[WPW-1:1], amt_d_q);
			end
			ST_CMP: begin
				ws_lt_q <= ws_q < wd_q;
				wd_lt_q <= wd_q < ws_q;
				bef_q   <= wrap_before(next_q, ws_q);
				aft_q   <= wrap_after(next_q, wd_q);
				da_q    <= ring_back(ws_q, next_q);
				db_q    <= ring_back(next_q, wd_q);
			end
			ST_ADJ: begin
				addr_q <= m_adj;
				idx_q  <= '0;
			end
			ST_STREAM: begin
				addr_q <= addr_inc;
				idx_q  <= idx_q + COUNT_W'(1);
			end
			default: ;
		endcase
	end

	assign even_we = clearing || (wr_acc && !wp_q[0]);
	assign odd_we  = clearing || (wr_acc && wp_q[0]);
	assign waddr   = clearing ? clr_q : wp_q[WPW-1:1];
	assign wdata   = clearing ? '0 : request.sample;

	aebs_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RING_FRAMES)
	) u_even (
		.clk  (clk),
		.we   (even_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(addr_q),
		.rdata(even_q)
	);

	aebs_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RING_FRAMES)
	) u_odd (
		.clk  (clk),
		.we   (odd_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(addr_q),
		.rdata(odd_q)
	);

	assign strobe = strobe_s1;
	always_comb begin
		result.left_word      = even_q;
		result.right_word     = odd_q;
		result.last_frame     = last_s1;
		result.adjustment     = adj_q;
		result.skips_so_far   = skip_q;
		result.repeats_so_far = rep_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> busy && !strobe)
		else $error("item or result during clearing sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= LAST_F && wp_q <= WP_LAST)
		else $error("ring position out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.last_frame |-> strobe)
		else $error("last frame flagged without result");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADJ |=> skip_q == $past(skip_q) || rep_q == $past(rep_q))
		else $error("both totals moved in one block");

endmodule

`default_nettype wire
